/* hw/rtl/frwa_pkg.sv */
// Package for the frame rate window averager: window length, fill value
// and the widths derived from them. No dependencies.
`default_nettype none
package frwa_pkg;
	localparam int WINDOW_SECONDS = 5;      // entries in the window ring, 1..16
	localparam logic [31:0] FILL_VALUE = 32'd70;
	localparam int CNT_W = 32;
	// ring slot index width
	localparam int SLOT_W = (WINDOW_SECONDS > 1) ? $clog2(WINDOW_SECONDS) : 1;
	// window sum never exceeds WINDOW_SECONDS * (2^32 - 1)
	localparam int SUM_W = CNT_W + $clog2(WINDOW_SECONDS);
	// remainder of the divide by the window length
	localparam int AREM_W = (WINDOW_SECONDS > 1) ? $clog2(WINDOW_SECONDS) : 1;
	localparam int STEP_W = $clog2(SUM_W + 1);
	localparam int OUT_DATA_W = 4 * CNT_W;

	typedef logic [CNT_W-1:0] count_t;
endpackage
`default_nettype wire

/* hw/rtl/frame_rate_window_average.sv */
// Frame rate meter over a sliding window of whole seconds.
// Depends on frwa_pkg (window length, widths, fill value).
// A frame in the same second goes straight to the publish step. A frame that starts
// a new second first adds up the window, one cycle per ring entry, then runs two
// shift-register dividers side by side, one quotient bit per cycle, then publishes.
// One frame is in work at a time: the next frame is taken once the previous one has
// been handed to the output register, which waits while that register is full and
// m_tready is low. The output register lets a new frame in while the previous result
// waits.
// Reset clears all counters and fills the ring with 70.
`default_nettype none
module frame_rate_window_average (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output      logic                             s_tready,
	input  wire logic [31:0]                      s_tdata,  // [31:0] seconds_now
	output      logic                             m_tvalid,
	input  wire logic                             m_tready,
	// [31:0] recent_average, [63:32] overall_rate,
	// [95:64] last_second_frames, [127:96] frame_number
	output      logic [frwa_pkg::OUT_DATA_W-1:0]  m_tdata,
	output      logic [0:0]                       m_tuser   // [0] second_rolled
);
	import frwa_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;  // wait for a frame
	localparam logic [1:0] ST_SUM  = 2'd1;  // add up the ring, one entry a cycle
	localparam logic [1:0] ST_DIV  = 2'd2;  // serial divides, one bit a cycle
	localparam logic [1:0] ST_PUB  = 2'd3;  // hand the result to the output register

	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_SECONDS - 1);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);
	localparam logic [AREM_W:0]   WIN_DIV   = (AREM_W + 1)'(WINDOW_SECONDS);

	logic [1:0]        state_q;
	count_t            frame_count_q;
	count_t            frames_at_last_q;
	count_t            last_second_q;
	count_t            recent_count_q;
	count_t            average_rate_q;
	count_t            long_rate_q;
	count_t            window_q [WINDOW_SECONDS];
	logic [SLOT_W-1:0] slot_q;
	logic [SLOT_W-1:0] sum_idx_q;
	logic [SUM_W-1:0]  acc_q;
	logic [STEP_W-1:0] step_q;
	logic              rolled_q;

	// dividers: frames since start / seconds, and window sum / window length
	logic [SUM_W-1:0]  div_num_q;
	count_t            div_rem_q;
	logic [SUM_W-1:0]  avg_num_q;
	logic [AREM_W-1:0] avg_rem_q;

	logic              accept;
	logic              new_second;
	logic              out_free;
	logic [SUM_W-1:0]  acc_nx;
	logic [CNT_W:0]    div_t;
	logic              div_ge;
	logic [CNT_W:0]    div_diff;
	logic [SUM_W-1:0]  div_num_nx;
	logic [AREM_W:0]   avg_t;
	logic              avg_ge;
	logic [AREM_W:0]   avg_diff;
	logic [SUM_W-1:0]  avg_num_nx;
	count_t            diff_frames;

	assign s_tready    = (state_q == ST_IDLE);
	assign accept      = s_tvalid && s_tready;
	assign new_second  = (s_tdata != last_second_q);
	assign out_free    = !m_tvalid || m_tready;
	assign diff_frames = frame_count_q - frames_at_last_q;
	assign acc_nx      = acc_q + SUM_W'(window_q[sum_idx_q]);

	// restoring division step: shift in the next dividend bit, subtract if it fits
	always_comb begin
		div_t      = {div_rem_q, div_num_q[SUM_W-1]};
		div_ge     = (div_t >= {1'b0, last_second_q});
		div_diff   = div_t - {1'b0, last_second_q};
		div_num_nx = {div_num_q[SUM_W-2:0], div_ge};
		avg_t      = {avg_rem_q, avg_num_q[SUM_W-1]};
		avg_ge     = (avg_t >= WIN_DIV);
		avg_diff   = avg_t - WIN_DIV;
		avg_num_nx = {avg_num_q[SUM_W-2:0], avg_ge};
	end

	// control and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			frame_count_q    <= '0;
			frames_at_last_q <= '0;
			last_second_q    <= '0;
			recent_count_q   <= '0;
			average_rate_q   <= '0;
			long_rate_q      <= '0;
			slot_q           <= '0;
			sum_idx_q        <= '0;
			step_q           <= '0;
			rolled_q         <= 1'b0;
			m_tvalid         <= 1'b0;
			for (int k = 0; k < WINDOW_SECONDS; k++) begin
				window_q[k] <= FILL_VALUE;
			end
		end else begin
			// drop the output once taken, unless a new result loads this cycle
			if (m_tready && !(state_q == ST_PUB && out_free)) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						frame_count_q <= frame_count_q + 1'b1;
						last_second_q <= s_tdata;
						rolled_q      <= new_second;
						if (new_second) begin
							// close the past second and record it in the ring
							recent_count_q   <= diff_frames;
							frames_at_last_q <= frame_count_q;
							window_q[slot_q] <= diff_frames;
							slot_q           <= (slot_q == LAST_SLOT) ? '0 : slot_q + 1'b1;
							sum_idx_q        <= '0;
							state_q          <= ST_SUM;
						end else begin
							state_q <= ST_PUB;
						end
					end
				end
				ST_SUM: begin
					if (sum_idx_q == LAST_SLOT) begin
						step_q  <= '0;
						state_q <= ST_DIV;
					end else begin
						sum_idx_q <= sum_idx_q + 1'b1;
					end
				end
				ST_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == LAST_STEP) begin
						average_rate_q <= avg_num_nx[CNT_W-1:0];
						// a zero second leaves the overall rate as it was
						if (last_second_q != '0) begin
							long_rate_q <= div_num_nx[CNT_W-1:0];
						end
						state_q <= ST_PUB;
					end
				end
				ST_PUB: begin
					if (out_free) begin
						m_tvalid <= 1'b1;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath shift registers and output payload, no reset needed
	always_ff @(posedge clk) begin
		if (accept && new_second) begin
			// dividend is the frame count before this frame, zero-extended
			div_num_q <= SUM_W'(frame_count_q);
			div_rem_q <= '0;
			acc_q     <= '0;
		end
		if (state_q == ST_SUM) begin
			acc_q <= acc_nx;
			if (sum_idx_q == LAST_SLOT) begin
				avg_num_q <= acc_nx;
				avg_rem_q <= '0;
			end
		end
		if (state_q == ST_DIV) begin
			div_num_q <= div_num_nx;
			div_rem_q <= div_ge ? div_diff[CNT_W-1:0] : div_t[CNT_W-1:0];
			avg_num_q <= avg_num_nx;
			avg_rem_q <= avg_ge ? avg_diff[AREM_W-1:0] : avg_t[AREM_W-1:0];
		end
		if (state_q == ST_PUB && out_free) begin
			m_tdata <= {frame_count_q, recent_count_q, long_rate_q, average_rate_q};
			m_tuser <= rolled_q;
		end
	end

	// a frame that changes the second must hold off the next transfer
	a_busy_after_roll: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && new_second) |=> !s_tready)
		else $error("input ready right after a new second");

	// the ring write pointer stays inside the window
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q <= LAST_SLOT)
		else $error("window slot out of range");

	// partial remainder of the seconds divide stays below the divisor
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && last_second_q != '0) |-> (div_rem_q < last_second_q))
		else $error("rate divider remainder out of range");

	// partial remainder of the window divide stays below the window length
	a_avg_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> ({1'b0, avg_rem_q} < WIN_DIV))
		else $error("average divider remainder out of range");

	// a result is loaded only into a free or draining output register
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> m_tvalid)
		else $error("pending result lost");
endmodule
`default_nettype wire
